// ===== rtl/emb_pkg.sv =====
// ----------------------------------------------------------------------------
// emb_pkg: shared types and codes for the extent map block translator
// Transaction payloads, function codes, register indexes and ALU controls.
// ----------------------------------------------------------------------------
package emb_pkg;

  typedef enum logic [1:0] {
    FUNC_WR_EXTENT = 2'd0,
    FUNC_WR_HOLE   = 2'd1,
    FUNC_LOG2PHYS  = 2'd2,
    FUNC_PHYS2LOG  = 2'd3
  } func_t;

  // register index as seen in paddr[2]
  localparam logic REG_EXTENTS_IN_USE = 1'b0;
  localparam logic REG_HOLES_IN_USE   = 1'b1;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CNT_REG_BITS  = 7;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_flags_t;

  typedef struct packed {
    func_t       func;
    logic [5:0]  entry_index;
    logic [47:0] extent_logical_start;
    logic [47:0] extent_physical_start;
    logic [47:0] extent_physical_end;
    logic [47:0] hole_start;
    logic [47:0] hole_length;
    logic [47:0] query_block;
  } in_item_t;

  typedef struct packed {
    logic [47:0] result_block;
    logic [5:0]  extent_found_index;
    logic        in_hole;
    logic        not_found;
  } out_item_t;

endpackage

// ===== rtl/extent_map_block_translator.sv =====
// ----------------------------------------------------------------------------
// extent_map_block_translator: logical/physical block translation
// Extent and hole tables in RAM, scanned one entry a cycle by a small
// sequencer around one shared add/compare unit.
// ----------------------------------------------------------------------------
//
//  port group   dir   handshake                  carries
//  in_*         in    in_valid / in_stall        in_item_t: table write or query
//  out_*        out   out_valid / out_stall      out_item_t: one per query
//  APB          in    psel, penable, pwrite      extents_in_use (0x0),
//                                                holes_in_use (0x4)
//
//  - A table write (extent or hole) leaves the sequencer idle; the block is ready
//    again on the next cycle.
//  - A query reads E <= extents_in_use extent entries and then H <= holes_in_use
//    hole entries; each table has a single read port and gives one entry a
//    cycle. The result is then handed over to the output register.
//  - in_stall is high for the whole of a query.
//  - A finished result sits in the output register; the next transaction is
//    taken while it waits, and only a second result waits on out_stall.
//  - rst_n is synchronous; the tables are not cleared, the counts return to
//    one extent and no holes.
// ----------------------------------------------------------------------------
module extent_map_block_translator import emb_pkg::*; #(
  parameter int MAX_EXTENTS = 64,
  parameter int MAX_HOLES   = 64,
  parameter int BLOCK_BITS  = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // item channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int BB  = BLOCK_BITS;
  localparam int EAW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int HAW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int ECW = $clog2(MAX_EXTENTS + 1);
  localparam int HCW = $clog2(MAX_HOLES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a transaction
  localparam logic [2:0] S_FE0   = 3'd1;  // forward: extent 0 on the read port
  localparam logic [2:0] S_FEXT  = 3'd2;  // forward: extent scan
  localparam logic [2:0] S_RSCAN = 3'd3;  // reverse: look for covering extent
  localparam logic [2:0] S_RES   = 3'd4;  // base + offset
  localparam logic [2:0] S_HSKIP = 3'd5;  // holes before the extent
  localparam logic [2:0] S_HSCAN = 3'd6;  // hole adjust
  localparam logic [2:0] S_DONE  = 3'd7;  // result to output register

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  logic [CNT_REG_BITS-1:0] ext_cnt_r;
  logic [CNT_REG_BITS-1:0] hole_cnt_r;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_cnt_r  <= CNT_REG_BITS'(1);
      hole_cnt_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_EXTENTS_IN_USE: ext_cnt_r  <= pwdata[CNT_REG_BITS-1:0];
        REG_HOLES_IN_USE:   hole_cnt_r <= pwdata[CNT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EXTENTS_IN_USE: prdata = CFG_DATA_BITS'(ext_cnt_r);
      REG_HOLES_IN_USE:   prdata = CFG_DATA_BITS'(hole_cnt_r);
      default:            prdata = '0;
    endcase
  end

  // counts above the table depth act as the depth
  logic [ECW-1:0] ne_clip;
  logic [HCW-1:0] nh_clip;

  assign ne_clip = (32'(ext_cnt_r) > MAX_EXTENTS) ? ECW'(MAX_EXTENTS) : ECW'(ext_cnt_r);
  assign nh_clip = (32'(hole_cnt_r) > MAX_HOLES) ? HCW'(MAX_HOLES) : HCW'(hole_cnt_r);

  // --------------------------------------------------------------------------
  // Tables: extent {logical, phys start, phys end}, hole {start, length}
  // --------------------------------------------------------------------------
  logic            ext_we;
  logic [EAW-1:0]  ext_raddr;
  logic [3*BB-1:0] ext_rdata;
  logic            hole_we;
  logic [HAW-1:0]  hole_raddr;
  logic [2*BB-1:0] hole_rdata;
  logic [BB-1:0]   ext_l, ext_ps, ext_pe, hole_s, hole_len;

  emb_ram #(.WIDTH(3*BB), .DEPTH(MAX_EXTENTS)) u_ext_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (EAW'(in_data.entry_index)),
    .wdata ({BB'(in_data.extent_logical_start),
             BB'(in_data.extent_physical_start),
             BB'(in_data.extent_physical_end)}),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  emb_ram #(.WIDTH(2*BB), .DEPTH(MAX_HOLES)) u_hole_ram (
    .clk   (clk),
    .we    (hole_we),
    .waddr (HAW'(in_data.entry_index)),
    .wdata ({BB'(in_data.hole_start), BB'(in_data.hole_length)}),
    .raddr (hole_raddr),
    .rdata (hole_rdata)
  );

  assign ext_l    = ext_rdata[3*BB-1:2*BB];
  assign ext_ps   = ext_rdata[2*BB-1:BB];
  assign ext_pe   = ext_rdata[BB-1:0];
  assign hole_s   = hole_rdata[2*BB-1:BB];
  assign hole_len = hole_rdata[BB-1:0];

  // --------------------------------------------------------------------------
  // Shared add/compare unit
  // --------------------------------------------------------------------------
  alu_op_t    add_op;
  logic [BB-1:0] add_a, add_b, add_y, cmp_a, cmp_b;
  logic       add_borrow;
  cmp_flags_t cmp;

  emb_alu #(.W(BB)) u_alu (
    .add_op     (add_op),
    .add_a      (add_a),
    .add_b      (add_b),
    .add_y      (add_y),
    .add_borrow (add_borrow),
    .cmp_a      (cmp_a),
    .cmp_b      (cmp_b),
    .cmp        (cmp)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [2:0]     state_r, state_nxt;
  logic           rev_r, rev_nxt;         // physical to logical query
  logic [BB-1:0]  q_r, q_nxt;
  logic [ECW-1:0] ne_r, ne_nxt, k_r, k_nxt, k_inc;
  logic [HCW-1:0] nh_r, nh_nxt, h_r, h_nxt, h_inc;
  logic [EAW-1:0] cur_r, cur_nxt;
  logic [BB-1:0]  cur_l_r, cur_l_nxt;     // logical start of chosen extent
  logic [BB-1:0]  base_r, base_nxt;
  logic [BB-1:0]  diff_r, diff_nxt;
  logic [BB-1:0]  acc_r, acc_nxt;
  logic           hole_r, hole_nxt;
  logic           miss_r, miss_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;
  logic           in_acc;
  logic           out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign k_inc    = k_r + ECW'(1);
  assign h_inc    = h_r + HCW'(1);

  always_comb begin
    state_nxt     = state_r;
    rev_nxt       = rev_r;
    q_nxt         = q_r;
    ne_nxt        = ne_r;
    nh_nxt        = nh_r;
    k_nxt         = k_r;
    h_nxt         = h_r;
    cur_nxt       = cur_r;
    cur_l_nxt     = cur_l_r;
    base_nxt      = base_r;
    diff_nxt      = diff_r;
    acc_nxt       = acc_r;
    hole_nxt      = hole_r;
    miss_nxt      = miss_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    ext_we        = 1'b0;
    hole_we       = 1'b0;
    ext_raddr     = '0;
    hole_raddr    = '0;
    add_op        = ALU_SUB;
    add_a         = q_r;
    add_b         = ext_l;
    cmp_a         = q_r;
    cmp_b         = ext_l;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          q_nxt    = BB'(in_data.query_block);
          ne_nxt   = ne_clip;
          nh_nxt   = nh_clip;
          k_nxt    = '0;
          h_nxt    = '0;
          cur_nxt  = '0;
          acc_nxt  = '0;
          hole_nxt = 1'b0;
          miss_nxt = 1'b0;
          case (in_data.func)
            FUNC_WR_EXTENT: ext_we  = (32'(in_data.entry_index) < MAX_EXTENTS);
            FUNC_WR_HOLE:   hole_we = (32'(in_data.entry_index) < MAX_HOLES);
            FUNC_LOG2PHYS: begin
              rev_nxt   = 1'b0;
              state_nxt = S_FE0;
            end
            FUNC_PHYS2LOG: begin
              rev_nxt = 1'b1;
              if (ne_clip == '0) begin
                miss_nxt  = 1'b1;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RSCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_FE0: begin
        // extent 0 is the fallback; offset q - L kept for later
        diff_nxt  = add_y;
        base_nxt  = ext_ps;
        cur_l_nxt = ext_l;
        cur_nxt   = '0;
        k_nxt     = ECW'(1);
        if (ECW'(1) < ne_r) begin
          ext_raddr = EAW'(1);
          state_nxt = S_FEXT;
        end else begin
          state_nxt = S_RES;
        end
      end

      S_FEXT: begin
        if (cmp.lt) begin
          state_nxt = S_RES;            // logical start above the query
        end else begin
          diff_nxt  = add_y;
          base_nxt  = ext_ps;
          cur_l_nxt = ext_l;
          cur_nxt   = k_r[EAW-1:0];
          if (k_inc < ne_r) begin
            ext_raddr = k_inc[EAW-1:0];
            k_nxt     = k_inc;
          end else begin
            state_nxt = S_RES;
          end
        end
      end

      S_RSCAN: begin
        // adder: q - phys start (borrow: start above q); compare: end < q
        add_b = ext_ps;
        cmp_a = ext_pe;
        cmp_b = q_r;
        if (!(cmp.lt || add_borrow)) begin
          diff_nxt  = add_y;
          base_nxt  = ext_l;
          cur_l_nxt = ext_l;
          cur_nxt   = k_r[EAW-1:0];
          state_nxt = S_RES;
        end else if (k_inc < ne_r) begin
          ext_raddr = k_inc[EAW-1:0];
          k_nxt     = k_inc;
        end else begin
          miss_nxt  = 1'b1;
          cur_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_DONE;
        end
      end

      S_RES: begin
        add_op  = ALU_ADD;
        add_a   = base_r;
        add_b   = diff_r;
        acc_nxt = add_y;
        h_nxt   = '0;
        if (nh_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          hole_raddr = '0;
          state_nxt  = S_HSKIP;
        end
      end

      S_HSKIP: begin
        cmp_a = hole_s;
        cmp_b = cur_l_r;
        if (cmp.lt) begin
          if (h_inc < nh_r) begin
            hole_raddr = h_inc[HAW-1:0];
            h_nxt      = h_inc;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          // re-read the same entry for the adjust pass
          hole_raddr = h_r[HAW-1:0];
          state_nxt  = S_HSCAN;
        end
      end

      S_HSCAN: begin
        add_a = acc_r;
        add_b = hole_len;
        cmp_b = hole_s;
        if (rev_r) begin
          add_op = ALU_ADD;
          cmp_a  = acc_r;
        end else begin
          add_op = ALU_SUB;
          cmp_a  = q_r;
        end
        if (cmp.lt) begin
          state_nxt = S_DONE;           // hole starts beyond the bound
        end else if (!rev_r && cmp.eq) begin
          hole_nxt  = 1'b1;
          acc_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          acc_nxt = add_y;
          if (h_inc < nh_r) begin
            hole_raddr = h_inc[HAW-1:0];
            h_nxt      = h_inc;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.result_block       = 48'(acc_r);
          out_data_nxt.extent_found_index = 6'(cur_r);
          out_data_nxt.in_hole            = hole_r;
          out_data_nxt.not_found          = miss_r;
          state_nxt                       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rev_r      <= rev_nxt;
    q_r        <= q_nxt;
    ne_r       <= ne_nxt;
    nh_r       <= nh_nxt;
    k_r        <= k_nxt;
    h_r        <= h_nxt;
    cur_r      <= cur_nxt;
    cur_l_r    <= cur_l_nxt;
    base_r     <= base_nxt;
    diff_r     <= diff_nxt;
    acc_r      <= acc_nxt;
    hole_r     <= hole_nxt;
    miss_r     <= miss_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/emb_ram.sv =====
// ----------------------------------------------------------------------------
// emb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module emb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/emb_alu.sv =====
// ----------------------------------------------------------------------------
// emb_alu: shared add/subtract and compare unit
// One wide adder (borrow gives unsigned a < b) and one magnitude comparator.
// ----------------------------------------------------------------------------
module emb_alu import emb_pkg::*; #(
  parameter int W = 48
) (
  input  alu_op_t     add_op,
  input  logic [W-1:0] add_a,
  input  logic [W-1:0] add_b,
  output logic [W-1:0] add_y,
  output logic         add_borrow,
  input  logic [W-1:0] cmp_a,
  input  logic [W-1:0] cmp_b,
  output cmp_flags_t   cmp
);

  logic         sub;
  logic [W:0]   sum;

  assign sub = (add_op == ALU_SUB);
  // subtract as a + ~b + 1; carry out low means borrow
  assign sum = {1'b0, add_a} + {1'b0, add_b ^ {W{sub}}} + {{W{1'b0}}, sub};
  assign add_y      = sum[W-1:0];
  assign add_borrow = sub & ~sum[W];

  assign cmp.lt = (cmp_a < cmp_b);
  assign cmp.eq = (cmp_a == cmp_b);

endmodule

// ===== rtl/emb_checker.sv =====
// ----------------------------------------------------------------------------
// emb_checker: port-level checks for the extent map block translator
// Watches both transaction channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module emb_checker import emb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a held result must not change under it
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // hole and miss flags are exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.in_hole && out_data.not_found))
    else $error("hole and miss both flagged");

  // a hole or a miss gives block 0; a miss also gives extent 0
  a_hole_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_hole |-> out_data.result_block == '0)
    else $error("hole result not zero");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.not_found |->
      out_data.result_block == '0 && out_data.extent_found_index == '0)
    else $error("miss result not zero");

  // a table write finishes in its own cycle
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.func == FUNC_WR_EXTENT || in_data.func == FUNC_WR_HOLE) |=> !in_stall)
    else $error("stalled after table write");

endmodule

bind extent_map_block_translator emb_checker u_emb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_extent_map_block_translator.sv =====
// ----------------------------------------------------------------------------
// tb_extent_map_block_translator: self-checking bench for the block translator
// Loads sorted extent and hole tables, runs logical and physical lookups at
// many table sizes, and checks every result against a behavioural predictor
// under random gaps, random back-pressure and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_extent_map_block_translator;
  timeunit 1ns;
  timeprecision 1ps;
  import emb_pkg::*;

  localparam int          MAX_ENTRIES  = 64;
  localparam int          SETTLE_WAIT  = 150;        // longer than the worst query plus handover
  localparam int          CYCLE_LIMIT  = 2_000_000;
  localparam logic [47:0] ALL_ONES     = '1;

  // --------------------------------------------------------------------------
  // DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     psel      = 1'b0;
  logic                     penable   = 1'b0;
  logic                     pwrite    = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr     = '0;
  logic [CFG_DATA_BITS-1:0] pwdata    = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  extent_map_block_translator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the tables and the two counts.
  // --------------------------------------------------------------------------
  logic [47:0] ext_logical [MAX_ENTRIES];
  logic [47:0] ext_pstart  [MAX_ENTRIES];
  logic [47:0] ext_pend    [MAX_ENTRIES];
  logic [47:0] hole_first  [MAX_ENTRIES];
  logic [47:0] hole_len    [MAX_ENTRIES];
  logic [6:0]  extents_cnt = 7'd1;
  logic [6:0]  holes_cnt   = 7'd0;

  out_item_t expected_translations [$];

  // bookkeeping
  int  mismatches    = 0;
  int  items_sent    = 0;
  int  log_lookups   = 0;
  int  phys_lookups  = 0;
  int  table_writes  = 0;
  int  misses_seen   = 0;
  int  holes_seen    = 0;
  int  cfg_writes    = 0;
  int  phases_run    = 0;
  int  cycle_count   = 0;
  bit  tx_gaps_on    = 1'b1;

  // receiver side state, owned by the result process
  int        hold_request = 0;
  int        hold_left    = 0;
  int        seg_left     = 0;
  bit        seg_stall    = 1'b0;
  int        seg_pick;
  out_item_t want;

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // counts above the table depth behave as the depth
  function automatic int live_extents();
    return (extents_cnt > 7'd64) ? MAX_ENTRIES : int'(extents_cnt);
  endfunction

  function automatic int live_holes();
    return (holes_cnt > 7'd64) ? MAX_ENTRIES : int'(holes_cnt);
  endfunction

  // first hole whose start is not below the chosen extent's logical start
  function automatic int first_hole_from(input logic [47:0] lstart, input int nh);
    int h;
    h = 0;
    while (h < nh && hole_first[h] < lstart) h++;
    return h;
  endfunction

  // --------------------------------------------------------------------------
  // Expected result of one lookup. All sums wrap at 48 bits.
  // --------------------------------------------------------------------------
  function automatic out_item_t translate_block(input func_t f, input logic [47:0] q);
    int          ne;
    int          nh;
    int          cur;
    int          h;
    logic [47:0] acc;
    logic        stop;
    out_item_t   r;
    ne  = live_extents();
    nh  = live_holes();
    r   = '0;
    cur = 0;
    if (f == FUNC_LOG2PHYS) begin
      // last extent starting at or below q; extent 0 when none does
      while (cur + 1 < ne && ext_logical[cur + 1] <= q) cur++;
      acc  = ext_pstart[cur] + q - ext_logical[cur];
      h    = first_hole_from(ext_logical[cur], nh);
      stop = 1'b0;
      while (!stop && h < nh && hole_first[h] <= q) begin
        if (hole_first[h] == q) begin
          r.in_hole = 1'b1;
          acc       = '0;
          stop      = 1'b1;
        end else begin
          acc = acc - hole_len[h];
          h++;
        end
      end
      r.result_block       = acc;
      r.extent_found_index = 6'(cur);
    end else begin
      // first extent whose physical range covers q
      while (cur < ne && (ext_pend[cur] < q || ext_pstart[cur] > q)) cur++;
      if (cur >= ne) begin
        r.not_found = 1'b1;
      end else begin
        acc = ext_logical[cur] + q - ext_pstart[cur];
        h   = first_hole_from(ext_logical[cur], nh);
        while (h < nh && hole_first[h] <= acc) begin
          acc = acc + hole_len[h];
          h++;
        end
        r.result_block       = acc;
        r.extent_found_index = 6'(cur);
      end
    end
    return r;
  endfunction

  // update tables or queue an expectation, at the accepting edge
  task automatic apply_item(input in_item_t it);
    items_sent++;
    case (it.func)
      FUNC_WR_EXTENT: begin
        ext_logical[it.entry_index] = it.extent_logical_start;
        ext_pstart[it.entry_index]  = it.extent_physical_start;
        ext_pend[it.entry_index]    = it.extent_physical_end;
        table_writes++;
      end
      FUNC_WR_HOLE: begin
        hole_first[it.entry_index] = it.hole_start;
        hole_len[it.entry_index]   = it.hole_length;
        table_writes++;
      end
      default: begin
        if (it.func == FUNC_LOG2PHYS) log_lookups++;
        else phys_lookups++;
        expected_translations.push_back(translate_block(it.func, it.query_block));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender. Entered and left on a rising-edge step; valid stays high on
  // return so that a following item can go out back to back.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!tx_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    apply_item(it);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it.func                  = func_t'($urandom_range(0, 3));
    it.entry_index           = 6'($urandom);
    it.extent_logical_start  = rand48();
    it.extent_physical_start = rand48();
    it.extent_physical_end   = rand48();
    it.hole_start            = rand48();
    it.hole_length           = rand48();
    it.query_block           = rand48();
    return it;
  endfunction

  function automatic func_t random_lookup();
    return ($urandom_range(0, 1) == 0) ? FUNC_LOG2PHYS : FUNC_PHYS2LOG;
  endfunction

  task automatic send_query(input func_t f, input logic [47:0] q);
    in_item_t it;
    it             = random_item();
    it.func        = f;
    it.query_block = q;
    send_item(it);
  endtask

  task automatic send_extent(input logic [5:0] slot, input logic [47:0] lstart,
                             input logic [47:0] pstart, input logic [47:0] pend);
    in_item_t it;
    it                       = random_item();
    it.func                  = FUNC_WR_EXTENT;
    it.entry_index           = slot;
    it.extent_logical_start  = lstart;
    it.extent_physical_start = pstart;
    it.extent_physical_end   = pend;
    send_item(it);
  endtask

  task automatic send_hole(input logic [5:0] slot, input logic [47:0] hstart,
                           input logic [47:0] hlen);
    in_item_t it;
    it             = random_item();
    it.func        = FUNC_WR_HOLE;
    it.entry_index = slot;
    it.hole_start  = hstart;
    it.hole_length = hlen;
    send_item(it);
  endtask

  // Query aimed at the interesting points of the current tables: extent
  // edges, hole starts and their neighbours, with some fully random values.
  function automatic logic [47:0] pick_query(input func_t f);
    int          ne;
    int          nh;
    int          i;
    int          j;
    logic [47:0] q;
    ne = live_extents();
    if (ne == 0) ne = 1;
    nh = live_holes();
    i  = $urandom_range(0, ne - 1);
    j  = (nh > 0) ? $urandom_range(0, nh - 1) : 0;
    if (f == FUNC_LOG2PHYS) begin
      case ($urandom_range(0, 6))
        0, 1:    q = (nh > 0) ? hole_first[j] : ext_logical[i];
        2:       q = ext_logical[i];
        3:       q = ext_logical[i] + 48'($urandom_range(0, 40));
        4:       q = ext_logical[i] - 48'd1;
        5:       q = (nh > 0) ? hole_first[j] + 48'd1 : rand48();
        default: q = rand48();
      endcase
    end else begin
      case ($urandom_range(0, 6))
        0:       q = ext_pstart[i];
        1:       q = ext_pend[i];
        2, 3:    q = ext_pstart[i] + 48'($urandom_range(0, 40));
        4:       q = ext_pend[i] + 48'd1;
        5:       q = ext_pstart[i] - 48'd1;
        default: q = rand48();
      endcase
    end
    return q;
  endfunction

  // Sorted extents (logical and physical ascending) and sorted holes that
  // fall among them. Only the first n entries of each table are rewritten.
  task automatic load_layout(input int n_ext, input int n_hole,
                             input logic [47:0] lbase, input int stride);
    logic [47:0] lpos;
    logic [47:0] ppos;
    logic [47:0] len;
    int          i;
    lpos = lbase;
    ppos = rand48();
    for (i = 0; i < n_ext; i++) begin
      len = 48'($urandom_range(1, stride));
      send_extent(6'(i), lpos, ppos, ppos + len - 48'd1);
      lpos = lpos + len + 48'($urandom_range(0, stride));
      ppos = ppos + len + 48'($urandom_range(0, stride));
    end
    lpos = lbase + 48'($urandom_range(0, stride));
    for (i = 0; i < n_hole; i++) begin
      send_hole(6'(i), lpos, 48'($urandom_range(1, stride / 4 + 1)));
      lpos = lpos + 48'($urandom_range(1, 2 * stride));
    end
  endtask

  // --------------------------------------------------------------------------
  // Idle wait: drop valid, wait for every result, then let any table write
  // still in flight complete before the registers are touched.
  // --------------------------------------------------------------------------
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_translations.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // APB write (setup + access) followed by a read-back of the same register
  task automatic write_count_reg(input logic reg_sel, input logic [6:0] value);
    logic [CFG_DATA_BITS-1:0] wdata;
    wdata   = {25'($urandom), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (reg_sel == REG_EXTENTS_IN_USE) extents_cnt = wdata[6:0];
    else holes_cnt = wdata[6:0];
    cfg_writes++;
    // read-back, straight into the next setup phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== {25'd0, wdata[6:0]})
      note_mismatch($sformatf("register %0d read %h, expected %h",
                              reg_sel, prdata, {25'd0, wdata[6:0]}));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_counts(input logic [6:0] n_ext, input logic [6:0] n_hole);
    settle();
    write_count_reg(REG_EXTENTS_IN_USE, n_ext);
    write_count_reg(REG_HOLES_IN_USE, n_hole);
  endtask

  // --------------------------------------------------------------------------
  // Result channel: check on accept, then choose the next stall value.
  // A hold-off request from a test takes priority over the random pattern.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_translations.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction: block %h index %0d hole %b miss %b",
                                out_data.result_block, out_data.extent_found_index,
                                out_data.in_hole, out_data.not_found));
      end else begin
        want = expected_translations.pop_front();
        if (out_data.result_block       !== want.result_block       ||
            out_data.extent_found_index !== want.extent_found_index ||
            out_data.in_hole            !== want.in_hole            ||
            out_data.not_found          !== want.not_found)
          note_mismatch($sformatf(
            "block %h/%h index %0d/%0d hole %b/%b miss %b/%b (expected/actual)",
            want.result_block, out_data.result_block,
            want.extent_found_index, out_data.extent_found_index,
            want.in_hole, out_data.in_hole, want.not_found, out_data.not_found));
        if (want.not_found) misses_seen++;
        if (want.in_hole) holes_seen++;
      end
    end

    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end

    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_pick = $urandom_range(0, 99);
        if (seg_pick < 6) begin
          // a clean stretch with no back-pressure at all
          seg_stall = 1'b0;
          seg_left  = $urandom_range(100, 300);
        end else begin
          seg_stall = ($urandom_range(0, 2) == 0);
          seg_left  = (seg_pick < 90) ? $urandom_range(1, 4) : $urandom_range(15, 60);
        end
      end
      seg_left--;
      out_stall <= seg_stall;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_translations.size());
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fill every slot of both tables before any lookup, then probe the counts
  // left by reset (one extent, no holes).
  task automatic test_fill_tables();
    load_layout(MAX_ENTRIES, MAX_ENTRIES, 48'd100, 16);
    send_query(FUNC_LOG2PHYS, ext_logical[0] + 48'd3);
    send_query(FUNC_PHYS2LOG, ext_pend[0]);
  endtask

  // Field extremes, both lookups, and the named corner cases
  task automatic test_directed();
    apply_counts(7'd64, 7'd64);
    send_query(FUNC_LOG2PHYS, 48'd0);                  // below every extent
    send_query(FUNC_LOG2PHYS, ALL_ONES);
    send_query(FUNC_LOG2PHYS, hole_first[3]);          // exactly on a hole
    send_query(FUNC_LOG2PHYS, ext_logical[5]);
    send_query(FUNC_LOG2PHYS, ext_logical[63] + 48'd1);
    send_query(FUNC_PHYS2LOG, ext_pstart[10]);
    send_query(FUNC_PHYS2LOG, ext_pend[10]);
    send_query(FUNC_PHYS2LOG, ext_pend[63] + 48'd1);   // past the last extent
    send_query(FUNC_PHYS2LOG, ALL_ONES);
    // no extents in use: forward uses extent 0, reverse misses
    apply_counts(7'd0, 7'd64);
    send_query(FUNC_LOG2PHYS, ext_logical[2]);
    send_query(FUNC_PHYS2LOG, ext_pstart[0]);
    // counts above the table depth
    apply_counts(7'd127, 7'd127);
    send_query(FUNC_LOG2PHYS, hole_first[63]);
    send_query(FUNC_PHYS2LOG, ext_pend[63]);
    apply_counts(7'd1, 7'd0);
    send_query(FUNC_LOG2PHYS, ext_logical[0] + 48'd7);
    send_query(FUNC_PHYS2LOG, ext_pstart[0]);
    // all-ones entries in the top slot, sums wrap
    send_extent(6'd63, ALL_ONES, ALL_ONES, ALL_ONES);
    send_hole(6'd63, ALL_ONES, ALL_ONES);
    apply_counts(7'd64, 7'd64);
    send_query(FUNC_LOG2PHYS, ALL_ONES);
    send_query(FUNC_PHYS2LOG, ALL_ONES);
    send_query(FUNC_LOG2PHYS, ALL_ONES - 48'd1);
  endtask

  // Long receiver hold-off with the sender pushing back to back: the output
  // register and the engine both fill and in_stall has to hold the sender.
  task automatic test_backpressure();
    int    k;
    func_t f;
    apply_counts(7'd64, 7'd64);
    tx_gaps_on   = 1'b0;
    hold_request = 1500;
    for (k = 0; k < 12; k++) begin
      f = k[0] ? FUNC_PHYS2LOG : FUNC_LOG2PHYS;
      send_query(f, pick_query(f));
    end
    tx_gaps_on = 1'b1;
  endtask

  // Sender stops until the pipe is empty, then carries on
  task automatic test_sender_pause();
    int    k;
    int    round;
    func_t f;
    apply_counts(7'd8, 7'd8);
    for (round = 0; round < 2; round++) begin
      for (k = 0; k < 6; k++) begin
        f = random_lookup();
        send_query(f, pick_query(f));
      end
      in_valid <= 1'b0;
      while (expected_translations.size() != 0) @(posedge clk);
      @(posedge clk);
    end
  endtask

  // Phases of: new counts, a fresh sorted layout, then mostly aimed lookups
  // with some random table writes mixed in to break the ordering.
  task automatic test_random_traffic(input int item_goal);
    int          stop_at;
    int          n_ext;
    int          n_hole;
    int          n_items;
    int          k;
    int          r;
    int          stride;
    logic [47:0] lbase;
    func_t       f;
    in_item_t    it;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) begin
      phases_run++;
      r = $urandom_range(0, 99);
      if (r < 60)      n_ext = $urandom_range(1, 8);
      else if (r < 85) n_ext = $urandom_range(9, 40);
      else if (r < 93) n_ext = 64;
      else if (r < 96) n_ext = 0;
      else             n_ext = $urandom_range(65, 127);
      r = $urandom_range(0, 99);
      if (r < 60)      n_hole = $urandom_range(0, 8);
      else if (r < 85) n_hole = $urandom_range(9, 40);
      else if (r < 94) n_hole = 64;
      else             n_hole = $urandom_range(65, 127);
      apply_counts(7'(n_ext), 7'(n_hole));

      r = $urandom_range(0, 99);
      if (r < 70)      lbase = 48'($urandom_range(0, 1000));
      else if (r < 90) lbase = rand48();
      else             lbase = ALL_ONES - 48'($urandom_range(0, 200));   // wraps
      r = $urandom_range(0, 99);
      if (r < 70)      stride = $urandom_range(2, 32);
      else if (r < 90) stride = $urandom_range(33, 4096);
      else             stride = $urandom_range(1 << 20, 1 << 28);

      tx_gaps_on = ($urandom_range(0, 3) != 0);
      load_layout((n_ext > MAX_ENTRIES) ? MAX_ENTRIES : n_ext,
                  (n_hole > MAX_ENTRIES) ? MAX_ENTRIES : n_hole, lbase, stride);

      n_items = $urandom_range(30, 70);
      for (k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < 85) begin
          f = random_lookup();
          send_query(f, pick_query(f));
        end else begin
          it      = random_item();
          it.func = ($urandom_range(0, 1) == 0) ? FUNC_WR_EXTENT : FUNC_WR_HOLE;
          send_item(it);
        end
      end
    end
    tx_gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_tables();
    test_directed();
    test_backpressure();
    test_sender_pause();
    test_random_traffic(1750);

    settle();
    if (expected_translations.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_translations.size()));

    $display("run covered %0d transactions: %0d forward and %0d reverse lookups, %0d table writes",
             items_sent, log_lookups, phys_lookups, table_writes);
    $display("%0d hole hits, %0d reverse misses, %0d register writes over %0d random phases",
             holes_seen, misses_seen, cfg_writes, phases_run);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== extent_map_block_translator.f =====
rtl/emb_pkg.sv
rtl/emb_ram.sv
rtl/emb_alu.sv
rtl/extent_map_block_translator.sv
rtl/emb_checker.sv
tb/tb_extent_map_block_translator.sv
